// ----- rtl/cbm_pkg.sv -----
// shared types and constants for the color blend mode unit
`default_nettype none

package cbm_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int MODE_BITS        = 4;
  localparam int NUM_LANES        = 4;
  localparam int ALPHA_LANE       = 3;
  localparam int CFG_ADDR_BITS    = 3;
  localparam int CFG_DATA_BITS    = 32;

  // register index taken from paddr above the byte offset
  localparam logic [CFG_ADDR_BITS-3:0] REG_DEFAULT_MODE = 1'b0;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_NONE     = 4'd0,
    MODE_SET      = 4'd1,
    MODE_MUL      = 4'd2,
    MODE_LIGHTEN  = 4'd3,
    MODE_DARKEN   = 4'd4,
    MODE_SCREEN   = 4'd5,
    MODE_DODGE    = 4'd6,
    MODE_CBURN    = 4'd7,
    MODE_ADD      = 4'd8,
    MODE_ADDALPHA = 4'd9,
    MODE_LBURN    = 4'd10,
    MODE_OVERLAY  = 4'd11,
    MODE_ALPHA    = 4'd12,
    MODE_DEFAULT  = 4'd13
  } mode_t;

  typedef struct packed {
    logic valid;
    logic use_div;
    logic burn;
    logic ovf;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/cbm_div.sv -----
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module cbm_div import cbm_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic [2*CHANNEL_BITS-1:0]   num,
  input  wire logic [CHANNEL_BITS-1:0]     den,
  output logic      [CHANNEL_BITS-1:0]     quot
);

  localparam int B = CHANNEL_BITS;

  logic [B-1:0] rem_r  [B];
  logic [B-1:0] low_r  [B];
  logic [B-1:0] den_r  [B];
  logic [B-1:0] quot_r [B];

  for (genvar k = 0; k < B; k++) begin : g_stage
    logic [B-1:0] rem_in;
    logic [B-1:0] low_in;
    logic [B-1:0] den_in;
    logic [B-1:0] q_in;
    logic [B:0]   trial;
    logic [B:0]   diff;
    logic         take;

    if (k == 0) begin : g_first
      assign rem_in = num[2*B-1:B];
      assign low_in = num[B-1:0];
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = quot_r[k-1];
    end

    assign trial = {rem_in, low_in[B-1]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      rem_r[k]  <= take ? diff[B-1:0] : trial[B-1:0];
      low_r[k]  <= {low_in[B-2:0], 1'b0};
      den_r[k]  <= den_in;
      quot_r[k] <= {q_in[B-2:0], take};
    end
  end

  assign quot = quot_r[B-1];

endmodule

`default_nettype wire

// ----- rtl/cbm_lane.sv -----
// one channel lane: products, divide by full scale, mode select, divider
`default_nettype none

module cbm_lane import cbm_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter bit IS_ALPHA     = 1'b0
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire mode_t                   in_mode,
  input  wire logic [CHANNEL_BITS-1:0] in_mix,
  input  wire logic [CHANNEL_BITS-1:0] in_old,
  input  wire logic [CHANNEL_BITS-1:0] in_new,
  output lane_ctl_t                    out_ctl,
  output logic      [CHANNEL_BITS-1:0] out_simple,
  output logic      [CHANNEL_BITS-1:0] out_quot
);

  localparam int B = CHANNEL_BITS;
  localparam logic [B-1:0] CMAX = '1;

  // x / CMAX for x up to 2*CMAX*CMAX, using 2^B = CMAX + 1
  function automatic logic [B:0] div_max(input logic [2*B:0] x);
    logic [B:0]   q0;
    logic [B+1:0] r;
    q0 = x[2*B:B];
    r  = {2'b00, x[B-1:0]} + {1'b0, q0};
    div_max = q0 + {{B{1'b0}}, (r >= {2'b00, CMAX})}
                 + {{B{1'b0}}, (r >= {1'b0, CMAX, 1'b0})};
  endfunction

  function automatic logic [B-1:0] sat(input logic [B+1:0] v);
    sat = (v > {2'b00, CMAX}) ? CMAX : v[B-1:0];
  endfunction

  function automatic logic [2*B-1:0] wide(input logic [B-1:0] v);
    wide = {{B{1'b0}}, v};
  endfunction

  // input stage
  logic [B-1:0]   inv_old;
  logic [B-1:0]   inv_new;
  logic [B-1:0]   inv_mix;
  logic [B-1:0]   num_base;
  logic [2*B-1:0] num_nxt;
  logic [B-1:0]   den_nxt;
  logic           ovf_nxt;

  assign inv_old  = CMAX - in_old;
  assign inv_new  = CMAX - in_new;
  assign inv_mix  = CMAX - in_mix;
  assign num_base = (in_mode == MODE_CBURN) ? inv_new : in_new;
  // base * CMAX as a shift and subtract
  assign num_nxt  = {num_base, {B{1'b0}}} - wide(num_base);
  assign den_nxt  = (in_mode == MODE_CBURN) ? in_old : inv_old;
  // quotient would not fit in B bits, saturates (covers zero divisor too)
  assign ovf_nxt  = (num_nxt[2*B-1:B] >= den_nxt);

  logic           vld_s1_r;
  mode_t          mode_s1_r;
  logic [B-1:0]   old_s1_r;
  logic [B-1:0]   new_s1_r;
  logic [2*B-1:0] p_on_r;
  logic [2*B-1:0] p_scr_r;
  logic [2*B-1:0] p_an_r;
  logic [2*B-1:0] p_oma_r;
  logic [2*B-1:0] p_na_r;
  logic [2*B-1:0] num_s1_r;
  logic [B-1:0]   den_s1_r;
  logic           ovf_s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s1_r <= 1'b0;
    end else begin
      vld_s1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    mode_s1_r <= in_mode;
    old_s1_r  <= in_old;
    new_s1_r  <= in_new;
    p_on_r    <= wide(in_old) * wide(in_new);
    p_scr_r   <= wide(inv_old) * wide(inv_new);
    p_an_r    <= wide(in_mix) * wide(in_new);
    p_oma_r   <= wide(in_old) * wide(inv_mix);
    p_na_r    <= wide(in_new) * wide(in_mix);
    num_s1_r  <= num_nxt;
    den_s1_r  <= den_nxt;
    ovf_s1_r  <= ovf_nxt;
  end

  // select stage
  logic         ovl_low;
  logic [2*B:0] dvd;
  logic [B:0]   quo;
  logic [B-1:0] quo_sat;
  logic [B:0]   sum_on;
  logic [B-1:0] res_nxt;
  lane_ctl_t    ctl_nxt;

  assign ovl_low = ({new_s1_r, 1'b0} < {1'b0, CMAX});
  assign sum_on  = {1'b0, old_s1_r} + {1'b0, new_s1_r};
  assign quo     = div_max(dvd);
  assign quo_sat = sat({1'b0, quo});

  always_comb begin
    case (mode_s1_r)
      MODE_MUL:      dvd = {1'b0, p_on_r};
      MODE_SCREEN:   dvd = {1'b0, p_scr_r};
      MODE_ADDALPHA: dvd = {1'b0, p_an_r};
      MODE_OVERLAY:  dvd = ovl_low ? {p_on_r, 1'b0} : {p_scr_r, 1'b0};
      MODE_ALPHA:    dvd = {1'b0, p_oma_r} + {1'b0, p_na_r};
      default:       dvd = '0;
    endcase
  end

  always_comb begin
    ctl_nxt.valid   = vld_s1_r;
    ctl_nxt.use_div = 1'b0;
    ctl_nxt.burn    = (mode_s1_r == MODE_CBURN);
    ctl_nxt.ovf     = ovf_s1_r;
    case (mode_s1_r)
      MODE_SET:      res_nxt = new_s1_r;
      MODE_MUL:      res_nxt = quo_sat;
      MODE_LIGHTEN:  res_nxt = (old_s1_r > new_s1_r) ? old_s1_r : new_s1_r;
      MODE_DARKEN:   res_nxt = (old_s1_r < new_s1_r) ? old_s1_r : new_s1_r;
      MODE_SCREEN:   res_nxt = CMAX - quo_sat;
      MODE_DODGE,
      MODE_CBURN: begin
        res_nxt         = old_s1_r;
        ctl_nxt.use_div = !IS_ALPHA;
      end
      MODE_ADD:      res_nxt = sat({1'b0, sum_on});
      MODE_ADDALPHA: res_nxt = sat({2'b00, old_s1_r} + {1'b0, quo});
      MODE_LBURN:    res_nxt = (sum_on > {1'b0, CMAX}) ?
                               sum_on[B-1:0] - CMAX : '0;
      MODE_OVERLAY: begin
        if (IS_ALPHA) begin
          res_nxt = old_s1_r;
        end else begin
          res_nxt = ovl_low ? quo_sat : CMAX - quo_sat;
        end
      end
      MODE_ALPHA:    res_nxt = quo_sat;
      default:       res_nxt = old_s1_r;
    endcase
  end

  lane_ctl_t    ctl_s2_r;
  logic [B-1:0] res_s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s2_r <= '0;
    end else begin
      ctl_s2_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_s2_r <= res_nxt;
  end

  // delay line that matches the divider depth
  lane_ctl_t    dl_ctl_r [B-1];
  logic [B-1:0] dl_res_r [B-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < B-1; k++) begin
        dl_ctl_r[k] <= '0;
      end
    end else begin
      dl_ctl_r[0] <= ctl_s2_r;
      for (int k = 1; k < B-1; k++) begin
        dl_ctl_r[k] <= dl_ctl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dl_res_r[0] <= res_s2_r;
    for (int k = 1; k < B-1; k++) begin
      dl_res_r[k] <= dl_res_r[k-1];
    end
  end

  assign out_ctl    = dl_ctl_r[B-2];
  assign out_simple = dl_res_r[B-2];

  if (IS_ALPHA) begin : g_no_div
    assign out_quot = '0;
  end else begin : g_div
    cbm_div #(
      .CHANNEL_BITS (CHANNEL_BITS)
    ) u_div (
      .clk  (clk),
      .num  (num_s1_r),
      .den  (den_s1_r),
      .quot (out_quot)
    );
  end

endmodule

`default_nettype wire

// ----- rtl/cbm_merge.sv -----
// merges lane results: finishes dodge and burn, registers the output pixel
`default_nettype none

module cbm_merge import cbm_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire lane_ctl_t [NUM_LANES-1:0]              ln_ctl,
  input  wire logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] ln_simple,
  input  wire logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] ln_quot,
  output logic                                        out_valid,
  output logic      [NUM_LANES-1:0][CHANNEL_BITS-1:0] out_ch
);

  localparam int B = CHANNEL_BITS;
  localparam logic [B-1:0] CMAX = '1;

  logic                          valid_r;
  logic [NUM_LANES-1:0][B-1:0]   ch_r;
  logic [NUM_LANES-1:0][B-1:0]   ch_nxt;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      logic [B-1:0] qs;
      qs = ln_ctl[l].ovf ? CMAX : ln_quot[l];
      if (!ln_ctl[l].use_div) begin
        ch_nxt[l] = ln_simple[l];
      end else if (ln_ctl[l].burn) begin
        ch_nxt[l] = CMAX - qs;
      end else begin
        ch_nxt[l] = qs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ln_ctl[0].valid;
    end
  end

  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;
  end

  assign out_valid = valid_r;
  assign out_ch    = ch_r;

endmodule

`default_nettype wire

// ----- rtl/color_blend_mode_unit_top.sv -----
// top level of the color blend mode unit: config register, lanes, merge
`default_nettype none

// Blends an existing RGBA pixel with an incoming one under the selected mode.
// A transaction is taken on every cycle that start is high (busy stays low),
// and its result appears with out_valid after the input registers, the
// divider stages and the merge register, one result per cycle in steady state.
// The depth is set by the color dodge and color burn divider, which resolves
// one quotient bit per pipeline stage. Results cannot be held off, so the
// receiver must take out_* on every cycle that out_valid is high.
// default_mode lives at byte address 0 and should only be written while no
// transaction is in flight.

module color_blend_mode_unit_top import cbm_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [MODE_BITS-1:0]     in_mode,
  input  wire logic [CHANNEL_BITS-1:0]  in_mix_alpha,
  input  wire logic [CHANNEL_BITS-1:0]  in_old_red,
  input  wire logic [CHANNEL_BITS-1:0]  in_old_green,
  input  wire logic [CHANNEL_BITS-1:0]  in_old_blue,
  input  wire logic [CHANNEL_BITS-1:0]  in_old_alpha,
  input  wire logic [CHANNEL_BITS-1:0]  in_new_red,
  input  wire logic [CHANNEL_BITS-1:0]  in_new_green,
  input  wire logic [CHANNEL_BITS-1:0]  in_new_blue,
  input  wire logic [CHANNEL_BITS-1:0]  in_new_alpha,
  output logic                          out_valid,
  output logic      [CHANNEL_BITS-1:0]  out_red,
  output logic      [CHANNEL_BITS-1:0]  out_green,
  output logic      [CHANNEL_BITS-1:0]  out_blue,
  output logic      [CHANNEL_BITS-1:0]  out_alpha,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic      [CFG_DATA_BITS-1:0] prdata,
  output logic                          pready
);

  localparam int LATENCY = CHANNEL_BITS + 2;

  // configuration
  logic [MODE_BITS-1:0] default_mode_r;
  logic [MODE_BITS-1:0] default_mode_nxt;
  logic                 reg_hit;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_BITS-1:2] == REG_DEFAULT_MODE);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    default_mode_nxt = default_mode_r;
    if (cfg_wr && reg_hit) begin
      default_mode_nxt = pwdata[MODE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_mode_r <= MODE_NONE;
    end else begin
      default_mode_r <= default_mode_nxt;
    end
  end

  assign prdata = reg_hit ? {{(CFG_DATA_BITS-MODE_BITS){1'b0}}, default_mode_r} : '0;

  // input side
  mode_t mode_res;
  logic  take;

  assign busy     = 1'b0;
  assign take     = start && !busy;
  assign mode_res = (in_mode == MODE_DEFAULT) ? mode_t'(default_mode_r) : mode_t'(in_mode);

  logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] old_ch;
  logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] new_ch;
  lane_ctl_t [NUM_LANES-1:0]              ln_ctl;
  logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] ln_simple;
  logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] ln_quot;
  logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] out_ch;

  assign old_ch = {in_old_alpha, in_old_blue, in_old_green, in_old_red};
  assign new_ch = {in_new_alpha, in_new_blue, in_new_green, in_new_red};

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    cbm_lane #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .IS_ALPHA     (l == ALPHA_LANE)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_valid   (take),
      .in_mode    (mode_res),
      .in_mix     (in_mix_alpha),
      .in_old     (old_ch[l]),
      .in_new     (new_ch[l]),
      .out_ctl    (ln_ctl[l]),
      .out_simple (ln_simple[l]),
      .out_quot   (ln_quot[l])
    );
  end

  cbm_merge #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ln_ctl    (ln_ctl),
    .ln_simple (ln_simple),
    .ln_quot   (ln_quot),
    .out_valid (out_valid),
    .out_ch    (out_ch)
  );

  assign out_red   = out_ch[0];
  assign out_green = out_ch[1];
  assign out_blue  = out_ch[2];
  assign out_alpha = out_ch[ALPHA_LANE];

  // every transaction comes out after the fixed pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##LATENCY out_valid)
    else $error("result missing after pipeline latency");

  // dodge keeps the existing alpha
  a_dodge_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    take && (mode_res == MODE_DODGE) |-> ##LATENCY
      (out_alpha == $past(in_old_alpha, LATENCY)))
    else $error("dodge did not pass existing alpha");

  // a register write reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && reg_hit |=> (prdata[MODE_BITS-1:0] == $past(pwdata[MODE_BITS-1:0])))
    else $error("default_mode readback mismatch");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// testbench for color_blend_mode_unit_top: random and directed pixels, self-checking predictor
module tb import cbm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = CHANNEL_BITS_DEF;
  localparam int unsigned CMAX = (1 << CB) - 1;
  localparam int LATENCY = CB + 2;

  typedef logic [NUM_LANES-1:0][CB-1:0] rgba_t;  // lane 0 red .. lane 3 alpha

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [CB-1:0]        mix;
    rgba_t                old_c;
    rgba_t                new_c;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [MODE_BITS-1:0] in_mode = '0;
  logic [CB-1:0] in_mix_alpha = '0;
  logic [CB-1:0] in_old_red = '0, in_old_green = '0, in_old_blue = '0, in_old_alpha = '0;
  logic [CB-1:0] in_new_red = '0, in_new_green = '0, in_new_blue = '0, in_new_alpha = '0;
  logic out_valid;
  logic [CB-1:0] out_red, out_green, out_blue, out_alpha;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic pready;

  color_blend_mode_unit_top dut (
    .clk, .rst_n, .start, .busy,
    .in_mode, .in_mix_alpha,
    .in_old_red, .in_old_green, .in_old_blue, .in_old_alpha,
    .in_new_red, .in_new_green, .in_new_blue, .in_new_alpha,
    .out_valid, .out_red, .out_green, .out_blue, .out_alpha,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk = ~clk;

  pixel_t pixel_q[$];
  rgba_t blend_exp_q[$];
  logic [MODE_BITS-1:0] dflt_mode_q = MODE_NONE;
  int mismatch_cnt = 0;
  pixel_t drv_pixel;
  logic took = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  bit draining = 1'b0;
  string lane_name[NUM_LANES] = '{"out_red", "out_green", "out_blue", "out_alpha"};

  function automatic void queue_pixel(pixel_t p);
    pixel_q.insert(pixel_q.size(), p);
  endfunction

  function automatic void queue_expect(rgba_t e);
    blend_exp_q.insert(blend_exp_q.size(), e);
  endfunction

  function automatic int unsigned sat_ch(int unsigned v);
    return (v > CMAX) ? CMAX : v;
  endfunction

  function automatic logic [CB-1:0] blend_lane(logic [MODE_BITS-1:0] m, int unsigned a,
                                               int unsigned o, int unsigned n, bit is_alpha);
    int unsigned r;
    case (m)
      MODE_SET:      r = n;
      MODE_MUL:      r = o * n / CMAX;
      MODE_LIGHTEN:  r = (o > n) ? o : n;
      MODE_DARKEN:   r = (o < n) ? o : n;
      MODE_SCREEN:   r = CMAX - (CMAX - o) * (CMAX - n) / CMAX;
      MODE_DODGE: begin
        if (is_alpha) r = o;
        else if (o == CMAX) r = CMAX;
        else r = sat_ch(n * CMAX / (CMAX - o));
      end
      MODE_CBURN: begin
        if (is_alpha) r = o;
        else if (o == 0) r = 0;
        else r = CMAX - sat_ch((CMAX - n) * CMAX / o);
      end
      MODE_ADD:      r = sat_ch(o + n);
      MODE_ADDALPHA: r = sat_ch(o + a * n / CMAX);
      MODE_LBURN:    r = (o + n > CMAX) ? o + n - CMAX : 0;
      MODE_OVERLAY: begin
        if (is_alpha) r = o;
        else if (2 * n < CMAX) r = sat_ch(2 * n * o / CMAX);
        else r = CMAX - sat_ch(2 * (CMAX - n) * (CMAX - o) / CMAX);
      end
      MODE_ALPHA:    r = (o * (CMAX - a) + n * a) / CMAX;
      default:       r = o;  // none, and the unused codes
    endcase
    return r[CB-1:0];
  endfunction

  function automatic rgba_t blend_pixel(pixel_t p, logic [MODE_BITS-1:0] dflt);
    logic [MODE_BITS-1:0] m;
    rgba_t res;
    m = (p.mode == MODE_DEFAULT) ? dflt : p.mode;
    for (int i = 0; i < NUM_LANES; i++)
      res[i] = blend_lane(m, 32'(p.mix), 32'(p.old_c[i]), 32'(p.new_c[i]), i == ALPHA_LANE);
    return res;
  endfunction

  // biased toward the saturation and overlay-threshold corners
  function automatic logic [CB-1:0] rand_chan();
    logic [CB-1:0] corner[6] = '{CB'(0), CB'(1), CB'(CMAX / 2), CB'(CMAX / 2 + 1),
                                 CB'(CMAX - 1), CB'(CMAX)};
    if ($urandom_range(0, 3) == 0) return corner[$urandom_range(0, 5)];
    return CB'($urandom);
  endfunction

  function automatic pixel_t mk_pixel(logic [MODE_BITS-1:0] m, logic [CB-1:0] a,
                                      rgba_t o, rgba_t n);
    pixel_t p;
    p.mode = m;
    p.mix = a;
    p.old_c = o;
    p.new_c = n;
    return p;
  endfunction

  function automatic rgba_t rand_rgba();
    rgba_t v;
    for (int i = 0; i < NUM_LANES; i++) v[i] = rand_chan();
    return v;
  endfunction

  function automatic pixel_t rand_pixel();
    logic [MODE_BITS-1:0] m;
    // lean on the default code so the register setting matters
    m = ($urandom_range(0, 3) == 0) ? MODE_DEFAULT : MODE_BITS'($urandom_range(0, 15));
    return mk_pixel(m, rand_chan(), rand_rgba(), rand_rgba());
  endfunction

  // sender: bursts, gaps, and now and then a full drain
  always @(negedge clk) begin
    if (rst_n && !(start && !took)) begin
      if (draining) begin
        start <= 1'b0;
        if (blend_exp_q.size() == 0) draining = 1'b0;
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pixel_q.size() == 0) begin
        start <= 1'b0;
      end else if (burst_left == 0) begin
        start <= 1'b0;
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                 : $urandom_range(1, 12);
        gap_left = $urandom_range(0, 6);
        draining = ($urandom_range(0, 15) == 0);
      end else begin
        drv_pixel <= pixel_q[0];
        in_mode <= pixel_q[0].mode;
        in_mix_alpha <= pixel_q[0].mix;
        {in_old_alpha, in_old_blue, in_old_green, in_old_red} <= pixel_q[0].old_c;
        {in_new_alpha, in_new_blue, in_new_green, in_new_red} <= pixel_q[0].new_c;
        void'(pixel_q.pop_front());
        start <= 1'b1;
        burst_left--;
      end
    end
  end

  // result checker and expectation capture
  always @(posedge clk) begin
    rgba_t want, got;
    if (rst_n) begin
      if (out_valid) begin
        if (blend_exp_q.size() == 0) begin
          $error("result with no transaction pending");
          mismatch_cnt++;
        end else begin
          want = blend_exp_q.pop_front();
          got = {out_alpha, out_blue, out_green, out_red};
          for (int i = 0; i < NUM_LANES; i++) begin
            if (got[i] !== want[i]) begin
              $error("%s: expected %0d, got %0d", lane_name[i], want[i], got[i]);
              mismatch_cnt++;
            end
          end
        end
      end
      if (start && !busy) queue_expect(blend_pixel(drv_pixel, dflt_mode_q));
      took <= start && !busy;
    end else begin
      took <= 1'b0;
    end
  end

  task automatic cfg_access(input bit wr, input logic [CFG_DATA_BITS-1:0] data,
                            output logic [CFG_DATA_BITS-1:0] rd);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {REG_DEFAULT_MODE, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_default_mode(logic [MODE_BITS-1:0] m);
    logic [CFG_DATA_BITS-1:0] rd;
    logic [CFG_DATA_BITS-1:0] wd;
    // junk in the unused upper bits must be ignored
    wd = {(CFG_DATA_BITS-MODE_BITS)'($urandom), m};
    cfg_access(1'b1, wd, rd);
    dflt_mode_q = m;
    cfg_access(1'b0, $urandom, rd);
    if (rd[MODE_BITS-1:0] !== m) begin
      $error("default_mode: expected %0d, got %0d", m, rd[MODE_BITS-1:0]);
      mismatch_cnt++;
    end
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0 || start || blend_exp_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  initial begin
    logic [MODE_BITS-1:0] settings[12] = '{MODE_ALPHA, MODE_DODGE, MODE_CBURN, MODE_OVERLAY,
                                           MODE_ADDALPHA, 4'hF, MODE_MUL, MODE_SCREEN,
                                           MODE_DEFAULT, MODE_ADD, MODE_LIGHTEN, MODE_NONE};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, default_mode still at its reset value
    for (int m = 0; m < 16; m++)
      queue_pixel(mk_pixel(MODE_BITS'(m), rand_chan(), rand_rgba(), rand_rgba()));
    queue_pixel(mk_pixel(MODE_ALPHA, '0, '0, '1));
    queue_pixel(mk_pixel(MODE_ALPHA, '1, '1, '0));
    // dodge with a full-scale existing color, then a near-zero divisor beside large ones
    queue_pixel(mk_pixel(MODE_DODGE, '0, '1, rand_rgba()));
    queue_pixel(mk_pixel(MODE_DODGE, '0, {8'd77, 8'd1, 8'd254, 8'd0},
                         {8'd3, 8'd255, 8'd255, 8'd255}));
    // color burn with a black existing color
    queue_pixel(mk_pixel(MODE_CBURN, '0, '0, rand_rgba()));
    queue_pixel(mk_pixel(MODE_CBURN, '1, {8'd9, 8'd255, 8'd1, 8'd2},
                         {8'd200, 8'd0, 8'd255, 8'd0}));
    // overlay on both sides of the half-scale threshold
    queue_pixel(mk_pixel(MODE_OVERLAY, '0, rand_rgba(),
                         {8'd99, 8'd255, 8'd128, 8'd127}));
    queue_pixel(mk_pixel(MODE_ADDALPHA, '1, '1, '1));
    queue_pixel(mk_pixel(MODE_LBURN, '0, {8'd128, 8'd255, 8'd0, 8'd100},
                         {8'd127, 8'd0, 8'd255, 8'd155}));
    for (int i = 0; i < 150; i++) queue_pixel(rand_pixel());
    wait_drained();

    foreach (settings[s]) begin
      set_default_mode(settings[s]);
      for (int i = 0; i < 90; i++) queue_pixel(rand_pixel());
      wait_drained();
    end

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
